// ===== rtl/jcc_pkg.sv =====
// Shared types and constants for the joystick cursor controller.
// Used by every module in rtl/; depends on nothing.
package jcc_pkg;

  localparam int COORD_BITS = 12;
  localparam int NUM_COLORS = 3;
  localparam int COLOR_W    = 2;
  localparam int PCT_W      = 7;
  localparam int SPEED_W    = 8;
  localparam int DEB_W      = 16;
  localparam int CANVAS_W   = 13;
  localparam int TIME_W     = 32;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  // step magnitude before the divide: deflection times speed
  localparam int PROD_W     = PCT_W + SPEED_W;
  localparam int DIV_CNT_W  = $clog2(PROD_W);
  localparam int EXT_W      = (CANVAS_W > COORD_BITS + 1) ? CANVAS_W : COORD_BITS + 1;
  localparam int SUM_W      = ((PROD_W > COORD_BITS) ? PROD_W : COORD_BITS) + 2;
  localparam int CNUM_W     = COLOR_W + 1;

  localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);

  localparam logic [PCT_W-1:0]    DZ_LOW_RST    = PCT_W'(45);
  localparam logic [PCT_W-1:0]    DZ_HIGH_RST   = PCT_W'(50);
  localparam logic [SPEED_W-1:0]  SPEED_RST     = SPEED_W'(20);
  localparam logic [PCT_W-1:0]    SHAKE_RST     = PCT_W'(20);
  localparam logic [DEB_W-1:0]    DEBOUNCE_RST  = DEB_W'(250);
  localparam logic [CANVAS_W-1:0] CANVAS_W_RST  = CANVAS_W'(640);
  localparam logic [CANVAS_W-1:0] CANVAS_H_RST  = CANVAS_W'(480);
  localparam logic [COORD_BITS-1:0] CURSOR_X_RST = COORD_BITS'(640 / 2);
  localparam logic [COORD_BITS-1:0] CURSOR_Y_RST = COORD_BITS'(480 / 2);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DZ_LOW   = 3'd0,
    REG_DZ_HIGH  = 3'd1,
    REG_SPEED    = 3'd2,
    REG_SHAKE    = 3'd3,
    REG_DEBOUNCE = 3'd4,
    REG_CANVAS_W = 3'd5,
    REG_CANVAS_H = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [PCT_W-1:0]    dz_low;
    logic [PCT_W-1:0]    dz_high;
    logic [SPEED_W-1:0]  max_speed;
    logic [PCT_W-1:0]    shake_thr;
    logic [DEB_W-1:0]    debounce;
    logic [CANVAS_W-1:0] canvas_w;
    logic [CANVAS_W-1:0] canvas_h;
  } cfg_t;

  typedef struct packed {
    logic capture;     // latch the input sample
    logic load_op;     // form dividend and divisor for the selected axis
    logic axis_y;      // 0: X axis, 1: Y axis
    logic div_start;   // launch the divider
    logic store_axis;  // clamp and hold the new position of the selected axis
    logic commit;      // load the result register and update frame state
  } dp_cmd_t;

endpackage

// ===== rtl/jcc_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on jcc_pkg for operand widths.
module jcc_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [jcc_pkg::PROD_W-1:0] dividend,
  input  logic [jcc_pkg::PCT_W-1:0]  divisor,
  output logic [jcc_pkg::PROD_W-1:0] quotient,
  output logic                      done
);
  import jcc_pkg::*;

  logic [PROD_W-1:0]    dvd_r;
  logic [PCT_W-1:0]     dvs_r;
  logic [PCT_W-1:0]     rem_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [PCT_W:0]       trial;
  logic                 fits;

  assign trial = {rem_r, dvd_r[PROD_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(PROD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in behind the dividend
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? PCT_W'(trial - {1'b0, dvs_r}) : trial[PCT_W-1:0];
      dvd_r <= {dvd_r[PROD_W-2:0], fits};
    end
  end

  assign quotient = dvd_r;
  assign done     = done_r;

endmodule

// ===== rtl/jcc_dp.sv =====
// Datapath: sample capture, per-axis step, cursor clamp, shake and colour logic.
// Depends on jcc_pkg and instantiates jcc_div.
module jcc_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  jcc_pkg::cfg_t                 cfg,
  input  jcc_pkg::dp_cmd_t              cmd,
  output logic                          div_done,
  input  logic [jcc_pkg::PCT_W-1:0]     in_joy_x,
  input  logic [jcc_pkg::PCT_W-1:0]     in_joy_y,
  input  logic [jcc_pkg::PCT_W-1:0]     in_accel_x,
  input  logic [jcc_pkg::PCT_W-1:0]     in_accel_y,
  input  logic                          in_color_button,
  input  logic                          in_reset_button,
  input  logic                          in_gui_reset,
  input  logic [jcc_pkg::TIME_W-1:0]    in_now_ms,
  output logic [jcc_pkg::COORD_BITS-1:0] out_line_start_x,
  output logic [jcc_pkg::COORD_BITS-1:0] out_line_start_y,
  output logic [jcc_pkg::COORD_BITS-1:0] out_line_end_x,
  output logic [jcc_pkg::COORD_BITS-1:0] out_line_end_y,
  output logic [jcc_pkg::COLOR_W-1:0]   out_color_index,
  output logic                          out_clear_canvas
);
  import jcc_pkg::*;

  localparam logic [EXT_W-1:0] EXT_MAX = EXT_W'(1) << COORD_BITS;

  // captured sample
  logic [PCT_W-1:0]  joy_x_r, joy_y_r, accel_x_r, accel_y_r;
  logic              cbtn_r, rbtn_r, gui_r;
  logic [TIME_W-1:0] now_r;

  // frame state
  logic [COORD_BITS-1:0] cursor_x_r, cursor_y_r;
  logic [PCT_W-1:0]      prev_ax_r, prev_ay_r;
  logic                  prev_cb_r;
  logic [TIME_W-1:0]     last_ms_r;
  logic [COLOR_W-1:0]    color_r;

  // per-axis working registers
  logic [PROD_W-1:0]     prod_r;
  logic [PCT_W-1:0]      dvs_r;
  logic                  neg_r;
  logic [COORD_BITS-1:0] end_x_r, end_y_r;

  // result register
  logic [COORD_BITS-1:0] sx_r, sy_r, ex_r, ey_r;
  logic [COLOR_W-1:0]    col_r;
  logic                  clr_r;

  logic [PCT_W-1:0]      v, diff, dvs_nxt;
  logic                  below, above;
  logic [PROD_W-1:0]     prod_nxt;
  logic [PROD_W-1:0]     quot;

  logic [COORD_BITS-1:0] pos, ext_m1, clamped;
  logic [CANVAS_W-1:0]   cw;
  logic [EXT_W-1:0]      cw_e, ext_m1_e;
  logic [SUM_W-1:0]      psum;

  logic [PCT_W-1:0]      dax, day;
  logic                  clear;
  logic                  advance;
  logic [TIME_W-1:0]     elapsed;
  logic [CNUM_W-1:0]     col_inc;
  logic [COLOR_W-1:0]    color_nxt;

  jcc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod_r),
    .divisor  (dvs_r),
    .quotient (quot),
    .done     (div_done)
  );

  // deflection outside the deadzone and its full-scale range
  always_comb begin
    v     = cmd.axis_y ? joy_y_r : joy_x_r;
    below = v < cfg.dz_low;
    above = !below && (v > cfg.dz_high) && (cfg.dz_high < PCT_FULL);
    if (below) begin
      diff    = cfg.dz_low - v;
      dvs_nxt = cfg.dz_low;
    end else if (above) begin
      diff    = v - cfg.dz_high;
      dvs_nxt = PCT_FULL - cfg.dz_high;
    end else begin
      diff    = '0;
      dvs_nxt = PCT_W'(1);
    end
    prod_nxt = PROD_W'(diff) * PROD_W'(cfg.max_speed);
  end

  // clamp the moved cursor to the canvas
  always_comb begin
    pos  = cmd.axis_y ? cursor_y_r : cursor_x_r;
    cw   = cmd.axis_y ? cfg.canvas_h : cfg.canvas_w;
    cw_e = EXT_W'(cw);
    if (cw_e == '0) begin
      ext_m1_e = '0;
    end else if (cw_e > EXT_MAX) begin
      ext_m1_e = EXT_MAX - EXT_W'(1);
    end else begin
      ext_m1_e = cw_e - EXT_W'(1);
    end
    ext_m1 = ext_m1_e[COORD_BITS-1:0];
    psum   = neg_r ? SUM_W'(pos) - SUM_W'(quot) : SUM_W'(pos) + SUM_W'(quot);
    if (psum[SUM_W-1]) begin
      clamped = '0;
    end else if (psum > SUM_W'(ext_m1)) begin
      clamped = ext_m1;
    end else begin
      clamped = psum[COORD_BITS-1:0];
    end
  end

  // shake, clear and colour
  always_comb begin
    dax     = (accel_x_r > prev_ax_r) ? accel_x_r - prev_ax_r : prev_ax_r - accel_x_r;
    day     = (accel_y_r > prev_ay_r) ? accel_y_r - prev_ay_r : prev_ay_r - accel_y_r;
    clear   = (dax > cfg.shake_thr) || (day > cfg.shake_thr) || !rbtn_r || gui_r;
    elapsed = now_r - last_ms_r;
    advance = !cbtn_r && prev_cb_r && (elapsed > TIME_W'(cfg.debounce));
    col_inc = CNUM_W'(color_r) + CNUM_W'(1);
    color_nxt = (col_inc >= CNUM_W'(NUM_COLORS)) ? '0 : col_inc[COLOR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      joy_x_r   <= in_joy_x;
      joy_y_r   <= in_joy_y;
      accel_x_r <= in_accel_x;
      accel_y_r <= in_accel_y;
      cbtn_r    <= in_color_button;
      rbtn_r    <= in_reset_button;
      gui_r     <= in_gui_reset;
      now_r     <= in_now_ms;
    end
    if (cmd.load_op) begin
      prod_r <= prod_nxt;
      dvs_r  <= dvs_nxt;
      // Y is inverted: a low stick moves the cursor up the index range
      neg_r  <= below ^ cmd.axis_y;
    end
    if (cmd.store_axis) begin
      if (cmd.axis_y) begin
        end_y_r <= clamped;
      end else begin
        end_x_r <= clamped;
      end
    end
    if (cmd.commit) begin
      sx_r  <= cursor_x_r;
      sy_r  <= cursor_y_r;
      ex_r  <= end_x_r;
      ey_r  <= end_y_r;
      col_r <= color_r;
      clr_r <= clear;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r <= CURSOR_X_RST;
      cursor_y_r <= CURSOR_Y_RST;
      prev_ax_r  <= '0;
      prev_ay_r  <= '0;
      prev_cb_r  <= 1'b1;
      last_ms_r  <= '0;
      color_r    <= '0;
    end else if (cmd.commit) begin
      cursor_x_r <= end_x_r;
      cursor_y_r <= end_y_r;
      prev_ax_r  <= accel_x_r;
      prev_ay_r  <= accel_y_r;
      prev_cb_r  <= cbtn_r;
      if (advance) begin
        color_r   <= color_nxt;
        last_ms_r <= now_r;
      end
    end
  end

  assign out_line_start_x = sx_r;
  assign out_line_start_y = sy_r;
  assign out_line_end_x   = ex_r;
  assign out_line_end_y   = ey_r;
  assign out_color_index  = col_r;
  assign out_clear_canvas = clr_r;

endmodule

// ===== rtl/jcc_ctrl.sv =====
// Controller: sequences capture, the two axis divides and the result transfer.
// Depends on jcc_pkg for the command struct.
module jcc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  logic             div_done,
  output jcc_pkg::dp_cmd_t cmd
);
  import jcc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_START,
    S_WAIT,
    S_COMMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   axis_r, axis_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt      = state_r;
    axis_nxt       = axis_r;
    cmd            = '0;
    cmd.axis_y     = axis_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          axis_nxt    = 1'b0;
          state_nxt   = S_MUL;
        end
      end
      S_MUL: begin
        cmd.load_op = 1'b1;
        state_nxt   = S_START;
      end
      S_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_WAIT;
      end
      S_WAIT: begin
        if (div_done) begin
          cmd.store_axis = 1'b1;
          if (axis_r) begin
            state_nxt = S_COMMIT;
          end else begin
            axis_nxt  = 1'b1;
            state_nxt = S_MUL;
          end
        end
      end
      S_COMMIT: begin
        // hold until the result register is free
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/joystick_cursor_controller.sv =====
// Joystick cursor controller: one line segment, colour and clear flag per frame sample.
// in_stall is high from an input transfer until the result commits, so no new sample is
// taken before the last is done. The 15-step divider runs once per axis.
// A stalled result holds in the output register; the next item can be computed but is
// not committed until it has moved. Synchronous active-low reset restores register
// defaults, centres the cursor on the default canvas, resets colour and button history.
module joystick_cursor_controller (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [jcc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [jcc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [jcc_pkg::PCT_W-1:0]         in_joy_x,
  input  logic [jcc_pkg::PCT_W-1:0]         in_joy_y,
  input  logic [jcc_pkg::PCT_W-1:0]         in_accel_x,
  input  logic [jcc_pkg::PCT_W-1:0]         in_accel_y,
  input  logic                              in_color_button,
  input  logic                              in_reset_button,
  input  logic                              in_gui_reset,
  input  logic [jcc_pkg::TIME_W-1:0]        in_now_ms,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [jcc_pkg::COORD_BITS-1:0]    out_line_start_x,
  output logic [jcc_pkg::COORD_BITS-1:0]    out_line_start_y,
  output logic [jcc_pkg::COORD_BITS-1:0]    out_line_end_x,
  output logic [jcc_pkg::COORD_BITS-1:0]    out_line_end_y,
  output logic [jcc_pkg::COLOR_W-1:0]       out_color_index,
  output logic                              out_clear_canvas
);
  import jcc_pkg::*;

  cfg_t    cfg_r;
  dp_cmd_t cmd;
  logic    div_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dz_low    <= DZ_LOW_RST;
      cfg_r.dz_high   <= DZ_HIGH_RST;
      cfg_r.max_speed <= SPEED_RST;
      cfg_r.shake_thr <= SHAKE_RST;
      cfg_r.debounce  <= DEBOUNCE_RST;
      cfg_r.canvas_w  <= CANVAS_W_RST;
      cfg_r.canvas_h  <= CANVAS_H_RST;
    end else if (cfg_we) begin
      // drop writes beyond the register list
      unique case (cfg_reg_t'(cfg_index))
        REG_DZ_LOW:   cfg_r.dz_low    <= cfg_data[PCT_W-1:0];
        REG_DZ_HIGH:  cfg_r.dz_high   <= cfg_data[PCT_W-1:0];
        REG_SPEED:    cfg_r.max_speed <= cfg_data[SPEED_W-1:0];
        REG_SHAKE:    cfg_r.shake_thr <= cfg_data[PCT_W-1:0];
        REG_DEBOUNCE: cfg_r.debounce  <= cfg_data[DEB_W-1:0];
        REG_CANVAS_W: cfg_r.canvas_w  <= cfg_data[CANVAS_W-1:0];
        REG_CANVAS_H: cfg_r.canvas_h  <= cfg_data[CANVAS_W-1:0];
        default: ;
      endcase
    end
  end

  jcc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .div_done  (div_done),
    .cmd       (cmd)
  );

  jcc_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .cmd              (cmd),
    .div_done         (div_done),
    .in_joy_x         (in_joy_x),
    .in_joy_y         (in_joy_y),
    .in_accel_x       (in_accel_x),
    .in_accel_y       (in_accel_y),
    .in_color_button  (in_color_button),
    .in_reset_button  (in_reset_button),
    .in_gui_reset     (in_gui_reset),
    .in_now_ms        (in_now_ms),
    .out_line_start_x (out_line_start_x),
    .out_line_start_y (out_line_start_y),
    .out_line_end_x   (out_line_end_x),
    .out_line_end_y   (out_line_end_y),
    .out_color_index  (out_color_index),
    .out_clear_canvas (out_clear_canvas)
  );

endmodule
